### hw/rtl/dcs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dcs_pkg - display coprocessor sequencer shared definitions
// Payload types, sequencer phases, register indexes and decode constants.
// ----------------------------------------------------------------------------
package dcs_pkg;

	localparam int AddrBits     = 21;
	localparam int WordBits     = 16;
	localparam int RegBits      = 9;
	localparam int CfgIndexBits = 1;
	localparam int CfgDataBits  = AddrBits;

	localparam logic [CfgIndexBits-1:0] CFG_START_ADDRESS     = 1'd0;
	localparam logic [CfgIndexBits-1:0] CFG_SHORT_WAIT_ADJUST = 1'd1;

	localparam logic [RegBits-1:0]  MinSafeReg = 9'h040;
	localparam logic [WordBits-1:0] AdjLow     = 16'hFF00;
	localparam logic [WordBits-1:0] AdjHigh    = 16'hFF51;
	localparam logic [WordBits-1:0] AdjValue   = 16'hFFDF;

	localparam logic [AddrBits-1:0] StepBytes = AddrBits'(2);
	localparam logic [AddrBits-1:0] SkipBytes = AddrBits'(6);

	typedef enum logic [2:0] {
		PH_FETCH = 3'd0,
		PH_MASK  = 3'd1,
		PH_DATA  = 3'd2,
		PH_WAIT  = 3'd3,
		PH_HALT  = 3'd4
	} phase_t;

	typedef enum logic [0:0] {
		OP_TICK    = 1'b0,
		OP_RESTART = 1'b1
	} opcode_t;

	typedef struct packed {
		logic                opcode;
		logic [WordBits-1:0] beam_position;
		logic [WordBits-1:0] fetch_word;
	} dcs_in_t;

	typedef struct packed {
		logic [AddrBits-1:0] fetch_address;
		logic                write_valid;
		logic [RegBits-1:0]  write_register;
		logic [WordBits-1:0] write_data;
		logic                halted;
		logic                waiting;
	} dcs_out_t;

endpackage
`default_nettype wire

### hw/rtl/dcs_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dcs_if - valid/ready channels of the display coprocessor sequencer
// One interface for the tick/restart items, one for the step results.
// ----------------------------------------------------------------------------
interface dcs_in_if;
	import dcs_pkg::*;

	logic    valid;
	logic    ready;
	dcs_in_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface dcs_out_if;
	import dcs_pkg::*;

	logic     valid;
	logic     ready;
	dcs_out_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

### hw/rtl/display_coprocessor_sequencer_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// display_coprocessor_sequencer_unit - display coprocessor step engine
// Runs one MOVE / WAIT / SKIP step per beam tick from the fetched word and
// reports the next fetch address, register writes and halt/wait status.
// ----------------------------------------------------------------------------
//  channel    dir  handshake      payload
//  item       in   valid/ready    opcode, beam_position, fetch_word
//  result     out  valid/ready    fetch_address, write_*, halted, waiting
//  wr_*       in   wr_en only     wr_index, wr_data
//
//  One item per cycle while the result channel is not stalled; each item yields
//  one result through the input register, then the result register.
//  The decode, compare and address add are combinational between the two.
//  A stalled result holds its register; a full input register holds its item,
//  so ready drops in the same cycle and stays low until the result transfers.
//  Reset clears phase, program and start address, first word; sets adjust.
// ----------------------------------------------------------------------------
module display_coprocessor_sequencer_unit (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	dcs_in_if.sink                                item,
	dcs_out_if.source                             result,
	input  wire logic                             wr_en,
	input  wire logic [dcs_pkg::CfgIndexBits-1:0] wr_index,
	input  wire logic [dcs_pkg::CfgDataBits-1:0]  wr_data
);
	import dcs_pkg::*;

	logic                valid_s1;
	dcs_in_t             item_s1;
	logic                out_valid_q;
	dcs_out_t            out_q;
	phase_t              phase_q, phase_d;
	logic [AddrBits-1:0] addr_q, addr_d;
	logic [WordBits-1:0] first_q, first_d;
	logic [AddrBits-1:0] start_q;
	logic                adjust_q;
	logic                fire_s1;
	dcs_out_t            out_d;
	logic [WordBits-1:0] cmp;
	logic [RegBits-1:0]  reg_off;

	assign fire_s1    = valid_s1 && (!out_valid_q || result.ready);
	assign item.ready = !valid_s1 || fire_s1;

	assign result.valid = out_valid_q;
	assign result.data  = out_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q  <= '0;
			adjust_q <= 1'b1;
		end else if (wr_en) begin
			case (wr_index)
				CFG_START_ADDRESS:     start_q  <= wr_data[AddrBits-1:0];
				CFG_SHORT_WAIT_ADJUST: adjust_q <= wr_data[0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			item_s1 <= item.data;
		end
	end

	// step decode
	always_comb begin
		phase_d = phase_q;
		addr_d  = addr_q;
		first_d = first_q;
		reg_off = first_q[RegBits-1:0];
		cmp     = first_q & item_s1.fetch_word;
		if (adjust_q && cmp > AdjLow && cmp < AdjHigh) begin
			cmp = AdjValue;
		end
		out_d.write_valid    = 1'b0;
		out_d.write_register = '0;
		out_d.write_data     = '0;

		if (item_s1.opcode == OP_RESTART) begin
			addr_d  = start_q;
			phase_d = PH_FETCH;
		end else begin
			case (phase_q)
				PH_FETCH: begin
					first_d = item_s1.fetch_word;
					addr_d  = addr_q + StepBytes;
					phase_d = item_s1.fetch_word[0] ? PH_MASK : PH_DATA;
				end
				PH_MASK: begin
					first_d = cmp;
					if (item_s1.fetch_word[0]) begin
						addr_d  = (item_s1.beam_position >= cmp) ? addr_q + SkipBytes
							: addr_q + StepBytes;
						phase_d = PH_FETCH;
					end else begin
						addr_d  = addr_q + StepBytes;
						phase_d = (item_s1.beam_position >= cmp) ? PH_FETCH : PH_WAIT;
					end
				end
				PH_DATA: begin
					addr_d = addr_q + StepBytes;
					if (reg_off < MinSafeReg) begin
						phase_d = PH_HALT;
					end else begin
						out_d.write_valid    = 1'b1;
						out_d.write_register = reg_off;
						out_d.write_data     = item_s1.fetch_word;
						phase_d              = PH_FETCH;
					end
				end
				PH_WAIT: begin
					if (item_s1.beam_position >= first_q) begin
						phase_d = PH_FETCH;
					end
				end
				default: ;
			endcase
		end

		out_d.fetch_address = addr_d;
		out_d.halted        = (phase_d == PH_HALT);
		out_d.waiting       = (phase_d == PH_WAIT);
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_FETCH;
			addr_q  <= '0;
			first_q <= '0;
		end else if (fire_s1) begin
			phase_q <= phase_d;
			addr_q  <= addr_d;
			first_q <= first_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || result.ready) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			out_q <= out_d;
		end
	end

endmodule
`default_nettype wire

### hw/rtl/dcs_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dcs_checker - port-level checks for the display coprocessor sequencer
// Watches the result channel and flags inconsistent step reports.
// ----------------------------------------------------------------------------
module dcs_checker (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              out_valid,
	input wire logic              out_ready,
	input wire dcs_pkg::dcs_out_t out_data
);
	import dcs_pkg::*;

	// no register write unless it is a legal MOVE
	a_write_safe: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.write_valid |-> out_data.write_register >= MinSafeReg)
		else $error("register write below safe offset");

	a_idle_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.write_valid |->
			out_data.write_register == '0 && out_data.write_data == '0)
		else $error("write fields set without a write");

	a_status_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_data.halted && out_data.waiting))
		else $error("halted and waiting together");

	a_write_running: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.write_valid |-> !out_data.halted && !out_data.waiting)
		else $error("write reported while halted or waiting");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

endmodule

bind display_coprocessor_sequencer_unit dcs_checker u_dcs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.out_data  (result.data)
);
`default_nettype wire

### verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench - display coprocessor sequencer check
// Feeds tick and restart transfers built as MOVE / WAIT / SKIP programs with
// random content, plus noise, under random stalls on both channels. Each
// result transfer is checked field by field against an in-order step model.
// ----------------------------------------------------------------------------
module testbench;
	import dcs_pkg::*;

	logic clk = 1'b0;
	logic arst_n;
	logic wr_en;
	logic [CfgIndexBits-1:0] wr_index;
	logic [CfgDataBits-1:0]  wr_data;

	dcs_in_if  item_ch ();
	dcs_out_if result_ch ();

	display_coprocessor_sequencer_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item_ch),
		.result   (result_ch),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	always #1 clk = ~clk;

	// Step model state and its copy of the registers
	phase_t              seq_phase;
	logic [AddrBits-1:0] seq_addr;
	logic [WordBits-1:0] seq_word;
	logic [AddrBits-1:0] cfg_start;
	logic                cfg_adjust;

	dcs_in_t  tick_items[$];
	dcs_out_t expected_steps[$];
	int       errors;
	int       gen_count;
	bit       quiet;
	bit       offer_taken;
	int       in_gap, in_calm, out_gap, out_calm;

	function automatic logic [WordBits-1:0] wait_threshold(input logic [WordBits-1:0] first,
			input logic [WordBits-1:0] mask);
		logic [WordBits-1:0] cmp;
		cmp = first & mask;
		if (cfg_adjust && cmp > AdjLow && cmp < AdjHigh) begin
			cmp = AdjValue;
		end
		return cmp;
	endfunction

	task automatic step_sequencer(input dcs_in_t it, output dcs_out_t r);
		r = '0;
		if (it.opcode == OP_RESTART) begin
			seq_addr  = cfg_start;
			seq_phase = PH_FETCH;
		end else begin
			case (seq_phase)
				PH_FETCH: begin
					seq_word  = it.fetch_word;
					seq_addr  = seq_addr + StepBytes;
					seq_phase = it.fetch_word[0] ? PH_MASK : PH_DATA;
				end
				PH_MASK: begin
					seq_addr = seq_addr + StepBytes;
					seq_word = wait_threshold(seq_word, it.fetch_word);
					if (it.fetch_word[0]) begin
						if (it.beam_position >= seq_word) begin
							seq_addr = seq_addr + AddrBits'(4);
						end
						seq_phase = PH_FETCH;
					end else begin
						seq_phase = (it.beam_position >= seq_word) ? PH_FETCH : PH_WAIT;
					end
				end
				PH_DATA: begin
					seq_addr = seq_addr + StepBytes;
					if (seq_word[RegBits-1:0] < MinSafeReg) begin
						seq_phase = PH_HALT;
					end else begin
						r.write_valid    = 1'b1;
						r.write_register = seq_word[RegBits-1:0];
						r.write_data     = it.fetch_word;
						seq_phase        = PH_FETCH;
					end
				end
				PH_WAIT: begin
					if (it.beam_position >= seq_word) begin
						seq_phase = PH_FETCH;
					end
				end
				default: begin
				end
			endcase
		end
		r.fetch_address = seq_addr;
		r.halted        = (seq_phase >= PH_HALT);
		r.waiting       = (seq_phase == PH_WAIT);
	endtask

	task automatic check_field(input string name, input logic [31:0] exp,
			input logic [31:0] act);
		if (act !== exp) begin
			$display("%0t mismatch %s: expected %0h, actual %0h", $realtime, name, exp, act);
			errors++;
		end
	endtask

	// Accept side: predict on every input transfer
	always @(posedge clk) begin
		dcs_out_t r;
		offer_taken = 1'b0;
		if (arst_n && item_ch.valid && item_ch.ready) begin
			offer_taken = 1'b1;
			step_sequencer(item_ch.data, r);
			expected_steps.push_back(r);
			void'(tick_items.pop_front());
		end
	end

	always @(negedge clk) begin
		if (in_calm > 0) begin
			in_calm--;
		end else if ($urandom_range(0, 63) == 0) begin
			in_calm = $urandom_range(20, 80);
		end
		if (!arst_n) begin
			item_ch.valid <= 1'b0;
		end else if (item_ch.valid && !offer_taken) begin
			// hold the offered transfer
		end else if (in_gap > 0) begin
			in_gap--;
			item_ch.valid <= 1'b0;
		end else if (tick_items.size() == 0) begin
			item_ch.valid <= 1'b0;
		end else if (!quiet && in_calm == 0 && $urandom_range(0, 9) == 0) begin
			in_gap = $urandom_range(0, 10);
			item_ch.valid <= 1'b0;
		end else begin
			item_ch.valid <= 1'b1;
			item_ch.data  <= tick_items[0];
		end
	end

	always @(negedge clk) begin
		if (out_calm > 0) begin
			out_calm--;
		end else if ($urandom_range(0, 63) == 0) begin
			out_calm = $urandom_range(20, 80);
		end
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
		end else if (out_gap > 0) begin
			out_gap--;
			result_ch.ready <= 1'b0;
		end else if (!quiet && out_calm == 0 && $urandom_range(0, 9) == 0) begin
			out_gap = $urandom_range(0, 10);
			result_ch.ready <= 1'b0;
		end else begin
			result_ch.ready <= 1'b1;
		end
	end

	// Result side: compare against the oldest prediction
	always @(posedge clk) begin
		dcs_out_t exp_r;
		dcs_out_t act_r;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			act_r = result_ch.data;
			if (expected_steps.size() == 0) begin
				$display("%0t unexpected result transfer: actual %0h", $realtime, act_r);
				errors++;
			end else begin
				exp_r = expected_steps.pop_front();
				check_field("fetch_address", exp_r.fetch_address, act_r.fetch_address);
				check_field("write_valid", exp_r.write_valid, act_r.write_valid);
				check_field("write_register", exp_r.write_register, act_r.write_register);
				check_field("write_data", exp_r.write_data, act_r.write_data);
				check_field("halted", exp_r.halted, act_r.halted);
				check_field("waiting", exp_r.waiting, act_r.waiting);
			end
		end
	end

	task automatic push_item(input opcode_t op, input logic [WordBits-1:0] pos,
			input logic [WordBits-1:0] word);
		dcs_in_t it;
		it.opcode        = op;
		it.beam_position = pos;
		it.fetch_word    = word;
		tick_items.push_back(it);
		gen_count++;
	endtask

	task automatic push_tick(input logic [WordBits-1:0] pos, input logic [WordBits-1:0] word);
		push_item(OP_TICK, pos, word);
	endtask

	task automatic push_restart();
		push_item(OP_RESTART, 16'($urandom), 16'($urandom));
	endtask

	// Programs built from well-formed instructions, with some noise and halts
	task automatic add_program(input int n);
		int kind;
		logic [WordBits-1:0] w0, mask, thr;
		gen_count = 0;
		while (gen_count < n) begin
			kind = $urandom_range(0, 99);
			w0   = 16'($urandom);
			mask = 16'($urandom);
			if (kind < 5) begin
				push_restart();
			end else if (kind < 10) begin
				// noise, then resync
				repeat ($urandom_range(1, 4)) begin
					push_item(($urandom_range(0, 3) == 0) ? OP_RESTART : OP_TICK,
						16'($urandom), 16'($urandom));
				end
				push_restart();
			end else if (kind < 13) begin
				// MOVE to a protected register: halt, idle ticks, restart
				w0[8:6] = 3'd0;
				w0[0]   = 1'b0;
				push_tick(16'($urandom), w0);
				push_tick(16'($urandom), 16'($urandom));
				repeat ($urandom_range(0, 3)) push_tick(16'($urandom), 16'($urandom));
				push_restart();
			end else if (kind < 50) begin
				w0[0] = 1'b0;
				if (w0[8:6] == 3'd0) begin
					w0[6] = 1'b1;
				end
				push_tick(16'($urandom), w0);
				push_tick(16'($urandom), mask);
			end else begin
				w0[0] = 1'b1;
				if ($urandom_range(0, 3) == 0) begin
					w0[15:8] = 8'hFF;
				end
				if ($urandom_range(0, 3) == 0) begin
					mask[15:8] = 8'hFF;
				end
				mask[0] = (kind >= 80);
				thr = wait_threshold(w0, mask);
				push_tick(16'($urandom), w0);
				if (thr > 0 && $urandom_range(0, 1) == 1) begin
					push_tick(16'($urandom_range(0, thr - 1)), mask);
					if (!mask[0]) begin
						repeat ($urandom_range(0, 4)) begin
							push_tick(16'($urandom_range(0, thr - 1)), 16'($urandom));
						end
						push_tick(16'($urandom_range(thr, 16'hFFFF)), 16'($urandom));
					end
				end else begin
					push_tick(16'($urandom_range(thr, 16'hFFFF)), mask);
				end
			end
		end
	endtask

	task automatic write_reg(input logic [CfgIndexBits-1:0] idx, input logic [CfgDataBits-1:0] val);
		@(negedge clk);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= val;
		@(negedge clk);
		wr_en <= 1'b0;
		if (idx == CFG_START_ADDRESS) begin
			cfg_start = val;
		end else begin
			cfg_adjust = val[0];
		end
	endtask

	task automatic drain();
		while (tick_items.size() != 0 || expected_steps.size() != 0) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
	endtask

	initial begin
		arst_n           = 1'b0;
		wr_en            = 1'b0;
		wr_index         = '0;
		wr_data          = '0;
		item_ch.valid    = 1'b0;
		item_ch.data     = '0;
		result_ch.ready  = 1'b0;
		seq_phase        = PH_FETCH;
		seq_addr         = '0;
		seq_word         = '0;
		cfg_start        = '0;
		cfg_adjust       = 1'b1;
		errors           = 0;
		quiet            = 1'b0;
		offer_taken      = 1'b0;
		in_gap           = 0;
		in_calm          = 0;
		out_gap          = 0;
		out_calm         = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		push_item(OP_RESTART, 16'h0000, 16'h0000);
		// MOVE to the top register offset, then to the lowest legal one
		push_tick(16'hFFFF, 16'hFFFE);
		push_tick(16'h0000, 16'hFFFF);
		push_tick(16'h0000, 16'h0040);
		push_tick(16'hFFFF, 16'h0000);
		// WAIT raised by the short-wait adjustment, held, then released
		push_tick(16'h1234, 16'hFF21);
		push_tick(16'hFF30, 16'hFFFE);
		push_tick(16'hFFDE, 16'hAAAA);
		push_tick(16'hFFDF, 16'h5555);
		// WAIT at the lower edge of the window, met at once
		push_tick(16'h0000, 16'hFF01);
		push_tick(16'hFF00, 16'hFF00);
		// SKIP taken just above the window, SKIP not taken
		push_tick(16'h0000, 16'hFF51);
		push_tick(16'hFF51, 16'hFFFF);
		push_tick(16'hFFFF, 16'h0101);
		push_tick(16'h0000, 16'h0101);
		// WAIT against zero
		push_tick(16'h0000, 16'h0001);
		push_tick(16'h0000, 16'h0000);
		// protected register: halt, stay halted, restart
		push_tick(16'h0000, 16'h003E);
		push_tick(16'h0000, 16'h1234);
		push_tick(16'hFFFF, 16'hFFFF);
		push_tick(16'h0000, 16'h0001);
		push_item(OP_RESTART, 16'hFFFF, 16'hFFFF);
		drain();

		write_reg(CFG_START_ADDRESS, CfgDataBits'(2097150));
		write_reg(CFG_SHORT_WAIT_ADJUST, CfgDataBits'(0));
		// address wraps past the top; window left alone with adjust off
		push_item(OP_RESTART, 16'h0000, 16'h0000);
		push_tick(16'h0000, 16'h0080);
		push_tick(16'h0000, 16'hBEEF);
		push_tick(16'h0000, 16'hFF21);
		push_tick(16'hFF20, 16'hFFFE);
		add_program(300);
		drain();

		write_reg(CFG_START_ADDRESS, CfgDataBits'(0));
		write_reg(CFG_SHORT_WAIT_ADJUST, CfgDataBits'(1));
		add_program(300);
		drain();

		write_reg(CFG_START_ADDRESS, CfgDataBits'($urandom_range(0, 2097150)));
		write_reg(CFG_SHORT_WAIT_ADJUST, CfgDataBits'($urandom_range(0, 1)));
		add_program(250);
		drain();
		quiet = 1'b1;
		add_program(100);
		drain();
		repeat (10) @(posedge clk);

		if (errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	initial begin
		#1_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
